>>> hw/rtl/wgau_pkg.sv
package wgau_pkg;

  localparam int DEF_MAX_ROWS  = 1024;
  localparam int DEF_MAX_COLS  = 64;
  localparam int DEF_FRAC_BITS = 24;

  // step size is always unsigned Q1.24
  localparam int LR_FRAC = 24;

  localparam int CFG_ROWS_W = 11;
  localparam int CFG_LR_W   = 25;
  localparam int CFG_DATA_W = 25;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [CFG_LR_W-1:0]   LR_RESET   = 25'd167772;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd1;

  localparam logic [2:0] OP_ACCUM  = 3'd0;
  localparam logic [2:0] OP_UPDATE = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic        [9:0]  row;
    logic        [5:0]  col;
    logic signed [31:0] activation;
    logic signed [31:0] out_grad;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic signed [31:0] grad_out;
    logic        [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic w_we;
    logic g_we;
  } store_req_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

endpackage

>>> hw/rtl/wgau_store.sv
module wgau_store #(
  parameter int DEPTH = wgau_pkg::DEF_MAX_ROWS * wgau_pkg::DEF_MAX_COLS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  wgau_pkg::store_req_t    req,
  input  logic [AW-1:0]           addr,
  input  logic signed [31:0]      w_wdata,
  input  logic signed [31:0]      g_wdata,
  output logic signed [31:0]      w_rdata,
  output logic signed [31:0]      g_rdata,
  output logic                    clr_busy
);
  import wgau_pkg::*;

  logic signed [31:0] weight_mem [DEPTH];
  logic signed [31:0] grad_mem   [DEPTH];
  logic [AW-1:0]      clr_addr;

  // sweep the gradient memory to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.w_we) begin
      weight_mem[addr] <= w_wdata;
    end
    if (req.rd_en) begin
      w_rdata <= weight_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      grad_mem[clr_addr] <= '0;
    end else if (req.g_we) begin
      grad_mem[addr] <= g_wdata;
    end
    if (req.rd_en) begin
      g_rdata <= grad_mem[addr];
    end
  end

endmodule

>>> hw/rtl/weight_gradient_accumulate_update_core.sv
// Each item is read from memory, multiplied into the product register and then written
// back with its result registered at the output; a new item is taken only once the last
// is done, and a held result stalls write back until the output register frees up.
// Reset: synchronous; afterwards the gradient memory is swept to zero, one entry per
// cycle, MAX_ROWS*MAX_COLS entries (65536 by default), with in_ready low.
// Configuration writes are taken in every cycle, including during the sweep.
module weight_gradient_accumulate_update_core #(
  parameter int MAX_ROWS  = wgau_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = wgau_pkg::DEF_MAX_COLS,
  parameter int FRAC_BITS = wgau_pkg::DEF_FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  wgau_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output wgau_pkg::out_item_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wgau_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wgau_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wgau_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = $clog2(DEPTH);
  localparam int RC_MIN = $clog2(MAX_ROWS + 1);
  localparam int RC_W   = (RC_MIN > CFG_ROWS_W) ? RC_MIN : CFG_ROWS_W;
  localparam int CC_MIN = $clog2(MAX_COLS + 1);
  localparam int CC_W   = (CC_MIN > 6) ? CC_MIN : 6;

  localparam logic signed [65:0] HALF_ACC = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [65:0] HALF_LR  = 66'sd1 <<< (LR_FRAC - 1);
  localparam logic signed [65:0] POS_MAX  = 66'sd2147483647;
  localparam logic signed [65:0] NEG_MIN  = -66'sd2147483648;

  state_t state, state_next;

  logic [CFG_ROWS_W-1:0] rows_in_use;
  logic [CFG_LR_W-1:0]   step_size;

  in_item_t      item;
  logic [AW-1:0] item_addr;
  logic          in_range;
  logic          bias_row;
  logic signed [64:0] prod;

  store_req_t         req;
  logic [AW-1:0]      mem_addr;
  logic signed [31:0] w_q;
  logic signed [31:0] g_q;
  logic signed [31:0] w_new;
  logic signed [31:0] g_new;
  logic               clr_busy;

  // range check and address of the incoming item
  logic [RC_W-1:0] rows_ext;
  logic [RC_W-1:0] rows_eff;
  logic [RC_W-1:0] row_ext;
  logic            acc_in_range;
  logic            acc_bias;
  logic [AW-1:0]   acc_addr;

  // execute stage
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_ext;
  logic signed [65:0] term;
  logic signed [65:0] g_sum;
  logic signed [65:0] delta;
  logic signed [65:0] w_diff;
  logic               g_sat;
  logic               w_sat;
  logic               out_free;
  logic               commit;
  logic [1:0]         exec_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      step_size   <= LR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS_IN_USE: rows_in_use <= cfg_data[CFG_ROWS_W-1:0];
        CFG_STEP_SIZE:   step_size   <= cfg_data[CFG_LR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_ext = RC_W'(rows_in_use);
    if (rows_ext == '0) begin
      rows_eff = RC_W'(1);
    end else if (rows_ext > RC_W'(MAX_ROWS)) begin
      rows_eff = RC_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_ext;
    end
    row_ext      = RC_W'(in_data.row);
    acc_in_range = (row_ext < rows_eff) && (CC_W'(in_data.col) < CC_W'(MAX_COLS));
    acc_bias     = (row_ext == rows_eff - RC_W'(1));
    acc_addr     = AW'(in_data.row) * AW'(MAX_COLS) + AW'(in_data.col);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (!clr_busy) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign out_free = !out_valid || out_ready;

  // outputs of the state machine
  always_comb begin
    in_ready  = (state == S_IDLE);
    commit    = (state == S_EXEC) && out_free;
    req.rd_en = (state == S_IDLE) && in_valid;
    req.w_we  = commit && in_range &&
                (item.opcode == OP_UPDATE || item.opcode == OP_WRITE);
    req.g_we  = commit && in_range &&
                (item.opcode == OP_ACCUM || item.opcode == OP_CLEAR);
    mem_addr  = (state == S_IDLE) ? acc_addr : item_addr;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item      <= in_data;
      item_addr <= acc_addr;
      in_range  <= acc_in_range;
      bias_row  <= acc_bias;
    end
  end

  // one shared multiplier: activation*out_grad or gradient*step_size
  always_comb begin
    if (item.opcode == OP_UPDATE) begin
      mul_a = g_q;
      mul_b = $signed({8'b0, step_size});
    end else begin
      mul_a = item.activation;
      mul_b = $signed({item.out_grad[31], item.out_grad});
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      prod <= mul_a * mul_b;
    end
  end

  // round to nearest with ties up is an arithmetic shift of the biased product; the bias row adds out_grad as is
  always_comb begin
    prod_ext = $signed({prod[64], prod});
    if (bias_row) begin
      term = $signed({{34{item.out_grad[31]}}, item.out_grad});
    end else begin
      term = (prod_ext + HALF_ACC) >>> FRAC_BITS;
    end
    g_sum  = $signed({{34{g_q[31]}}, g_q}) + term;
    delta  = (prod_ext + HALF_LR) >>> LR_FRAC;
    w_diff = $signed({{34{w_q[31]}}, w_q}) - delta;
    g_sat  = (g_sum > POS_MAX) || (g_sum < NEG_MIN);
    w_sat  = (w_diff > POS_MAX) || (w_diff < NEG_MIN);
  end

  always_comb begin
    w_new       = w_q;
    g_new       = g_q;
    exec_status = STAT_OK;
    case (item.opcode)
      OP_ACCUM: begin
        if (g_sum > POS_MAX) begin
          g_new = 32'sh7FFFFFFF;
        end else if (g_sum < NEG_MIN) begin
          g_new = 32'sh80000000;
        end else begin
          g_new = g_sum[31:0];
        end
        if (g_sat) exec_status = STAT_SAT;
      end
      OP_UPDATE: begin
        if (w_diff > POS_MAX) begin
          w_new = 32'sh7FFFFFFF;
        end else if (w_diff < NEG_MIN) begin
          w_new = 32'sh80000000;
        end else begin
          w_new = w_diff[31:0];
        end
        if (w_sat) exec_status = STAT_SAT;
      end
      OP_CLEAR: g_new = '0;
      OP_WRITE: w_new = item.write_value;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (in_range) begin
        out_data.weight_out <= w_new;
        out_data.grad_out   <= g_new;
        out_data.status     <= exec_status;
      end else begin
        out_data.weight_out <= '0;
        out_data.grad_out   <= '0;
        out_data.status     <= STAT_RANGE;
      end
    end
  end

  wgau_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .addr     (mem_addr),
    .w_wdata  (w_new),
    .g_wdata  (g_new),
    .w_rdata  (w_q),
    .g_rdata  (g_q),
    .clr_busy (clr_busy)
  );

endmodule
